>>> src/tes_pkg.sv
// Shared types and constants of the timed event sequencer.
package tes_pkg;

   // Most events sent out by one tick
   localparam int MAX_RESULTS = 32;
   localparam int FIRE_W      = 6;

   // Register map and reset values
   localparam logic REG_DURATION = 1'b0;
   localparam logic REG_LOOP     = 1'b1;
   localparam logic [31:0] DURATION_RESET = 32'd48000;

   // Command codes after classification
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_TICK,
      OP_RESTART,
      OP_NONE
   } op_type;

   // Opcodes as they arrive on the request channel
   localparam logic [1:0] OPC_INSERT  = 2'd0;
   localparam logic [1:0] OPC_TICK    = 2'd1;
   localparam logic [1:0] OPC_RESTART = 2'd2;

   // Back end sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_START,
      S_INS_CMP,
      S_INS_PUT,
      S_TICK_CHK,
      S_TICK_CMP,
      S_TICK_END,
      S_DONE
   } state_type;

   // One stored event
   typedef struct packed {
      logic [31:0] time_val;
      logic [1:0]  kind;
      logic [31:0] voice;
      logic [31:0] freq;
   } entry_type;

   // One classified command waiting for the back end
   typedef struct packed {
      op_type    op;
      entry_type ev;
   } cmd_type;

   // One result word
   typedef struct packed {
      logic        event_valid;
      logic [1:0]  kind;
      logic [31:0] voice;
      logic [31:0] freq;
      logic        last;
      logic        status;
      logic        playing;
   } res_type;

endpackage

>>> src/timed_event_sequencer.sv
// Timed event sequencer top level: configuration registers and channel ports.
//
// Usage: the req_ channel carries one command word: insert an event (time, kind,
// voice, frequency word), tick one sample, or restart playback. The rsp_ channel
// returns the result words of each command in order; rsp_last marks the final one.
// Insert, restart and unused opcodes give one word; a tick gives one word per fired
// event (at most 32), or a single empty word when nothing is due.
// All table access goes through one event memory with one write port and one
// registered read port. An insert moves each later entry up one place; a tick
// reads entries in order and fires each one that is due. Commands run one at a
// time; a two-word queue takes new requests while the back end is busy.
// The user writes duration and loop_enable over the APB port only while the
// block is idle; the block itself does not enforce this.
// Reset empties the table, zeroes counter and pointer and sets playback active;
// the memory is not cleared, since only filled entries are ever read.
// When the receiver stalls, the result register holds its word and the back end
// waits; requests keep entering until the queue is full.
module timed_event_sequencer #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_event_time,
   input  logic [1:0]  req_event_kind,
   input  logic [31:0] req_voice_id,
   input  logic [31:0] req_freq_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_valid,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_out_voice,
   output logic [31:0] rsp_out_freq,
   output logic        rsp_last,
   output logic        rsp_status,
   output logic        rsp_playing,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tes_pkg::*;

   logic [31:0] duration_ff;
   logic        loop_ff;
   logic        csr_wr;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd;
   res_type     rsp;

   // Configuration registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= DURATION_RESET;
         loop_ff     <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_DURATION: duration_ff <= pwdata;
            REG_LOOP:     loop_ff     <= pwdata[0];
            default:      loop_ff     <= loop_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DURATION: prdata = duration_ff;
         REG_LOOP:     prdata = {31'd0, loop_ff};
         default:      prdata = '0;
      endcase
   end

   tes_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_event_time (req_event_time),
      .req_event_kind (req_event_kind),
      .req_voice_id   (req_voice_id),
      .req_freq_word  (req_freq_word),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   tes_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .duration    (duration_ff),
      .loop_enable (loop_ff),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   // Unpack the result word
   assign rsp_event_valid = rsp.event_valid;
   assign rsp_out_kind    = rsp.kind;
   assign rsp_out_voice   = rsp.voice;
   assign rsp_out_freq    = rsp.freq;
   assign rsp_last        = rsp.last;
   assign rsp_status      = rsp.status;
   assign rsp_playing     = rsp.playing;

endmodule

>>> src/tes_front.sv
// Front end: accepts request words, classifies them and queues them.
module tes_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  logic [31:0]      req_event_time,
   input  logic [1:0]       req_event_kind,
   input  logic [31:0]      req_voice_id,
   input  logic [31:0]      req_freq_word,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output tes_pkg::cmd_type cmd
);
   import tes_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push, pop;

   // Classify the incoming word
   always_comb begin
      new_cmd.ev.time_val = req_event_time;
      new_cmd.ev.kind     = req_event_kind;
      new_cmd.ev.voice    = req_voice_id;
      new_cmd.ev.freq     = req_freq_word;
      case (req_opcode)
         OPC_INSERT:  new_cmd.op = OP_INSERT;
         OPC_TICK:    new_cmd.op = OP_TICK;
         OPC_RESTART: new_cmd.op = OP_RESTART;
         default:     new_cmd.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> src/tes_back.sv
// Back end: event table memory, insertion sort, tick playback and result register.
module tes_back #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      duration,
   input  logic             loop_enable,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  tes_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tes_pkg::res_type rsp
);
   import tes_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Event table memory
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [31:0]       counter_ff, counter_in;
   logic              active_ff, active_in;
   entry_type         pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [FIRE_W-1:0] nfire_ff, nfire_in;
   logic              status_ff, status_in;
   res_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   entry_type         mem_wdata;
   logic              emit;
   res_type           emit_res;
   logic              out_free;
   logic [31:0]       counter_inc;
   logic              wrap_hit;
   logic              tick_playing;
   logic [CW-1:0]     cnt_m1, idx_m1, idx_m2;
   logic              place;
   logic [CW-1:0]     place_pos;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign counter_inc  = counter_ff + 32'd1;
   assign wrap_hit     = (counter_inc >= duration);
   assign tick_playing = active_ff & ~(wrap_hit & ~loop_enable);
   assign cnt_m1       = cnt_ff - CW'(1);
   assign idx_m1       = idx_ff - CW'(1);
   assign idx_m2       = idx_ff - CW'(2);

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      counter_in    = counter_ff;
      active_in     = active_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      nfire_in      = nfire_ff;
      status_in     = status_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = cmd_ff.ev;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff[AW-1:0];
      emit          = 1'b0;
      emit_res      = '0;
      cmd_ready     = 1'b0;
      place         = 1'b0;
      place_pos     = idx_ff;

      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in    = cmd;
               status_in = 1'b0;
               case (cmd.op)
                  OP_INSERT: state_in = S_INS_START;
                  OP_TICK: begin
                     nfire_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_TICK_CHK;
                  end
                  OP_RESTART: begin
                     counter_in = '0;
                     ptr_in     = '0;
                     active_in  = 1'b1;
                     state_in   = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_INS_START: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               status_in = 1'b1;
               state_in  = S_DONE;
            end else if (cnt_ff == '0) begin
               place     = 1'b1;
               place_pos = '0;
            end else begin
               // start scanning from the top entry downwards
               idx_in    = cnt_ff;
               mem_re    = 1'b1;
               mem_raddr = cnt_m1[AW-1:0];
               state_in  = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            if (rd_data_ff.time_val > cmd_ff.ev.time_val) begin
               // move the later entry up by one
               mem_we    = 1'b1;
               mem_waddr = idx_ff[AW-1:0];
               mem_wdata = rd_data_ff;
               idx_in    = idx_m1;
               if (idx_ff == CW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_m2[AW-1:0];
               end
            end else begin
               place = 1'b1;
            end
         end

         S_INS_PUT: begin
            place = 1'b1;
         end

         S_TICK_CHK: begin
            if (ptr_ff < cnt_ff && nfire_ff < FIRE_W'(MAX_RESULTS)) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff[AW-1:0];
               state_in  = S_TICK_CMP;
            end else begin
               state_in = S_TICK_END;
            end
         end

         S_TICK_CMP: begin
            if (rd_data_ff.time_val <= counter_ff) begin
               if (!pend_valid_ff || out_free) begin
                  // send the held event on, now known not to be the last
                  if (pend_valid_ff) begin
                     emit                 = 1'b1;
                     emit_res.event_valid = 1'b1;
                     emit_res.kind        = pend_ff.kind;
                     emit_res.voice       = pend_ff.voice;
                     emit_res.freq        = pend_ff.freq;
                     emit_res.playing     = tick_playing;
                  end
                  pend_in       = rd_data_ff;
                  pend_valid_in = 1'b1;
                  ptr_in        = ptr_ff + CW'(1);
                  nfire_in      = nfire_ff + FIRE_W'(1);
                  state_in      = S_TICK_CHK;
               end
            end else begin
               state_in = S_TICK_END;
            end
         end

         S_TICK_END: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_res.last    = 1'b1;
               emit_res.playing = tick_playing;
               if (pend_valid_ff) begin
                  emit_res.event_valid = 1'b1;
                  emit_res.kind        = pend_ff.kind;
                  emit_res.voice       = pend_ff.voice;
                  emit_res.freq        = pend_ff.freq;
               end
               pend_valid_in = 1'b0;
               // advance the timeline, then wrap or stop at the end
               counter_in = counter_inc;
               if (wrap_hit) begin
                  if (loop_enable) begin
                     counter_in = '0;
                     ptr_in     = '0;
                  end else begin
                     active_in = 1'b0;
                  end
               end
               state_in = S_IDLE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_res.last    = 1'b1;
               emit_res.status  = status_ff;
               emit_res.playing = active_ff;
               state_in         = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // drop the new event into its slot and keep the next event in view
      if (place) begin
         mem_we    = 1'b1;
         mem_waddr = place_pos[AW-1:0];
         mem_wdata = cmd_ff.ev;
         cnt_in    = cnt_ff + CW'(1);
         if (place_pos < ptr_ff) begin
            ptr_in = ptr_ff + CW'(1);
         end
         state_in = S_DONE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         counter_ff    <= '0;
         active_ff     <= 1'b1;
         pend_valid_ff <= 1'b0;
         nfire_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         counter_ff    <= counter_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         nfire_ff      <= nfire_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      pend_ff   <= pend_in;
      status_ff <= status_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Play pointer never passes the fill level
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= cnt_ff)
      else $error("play pointer beyond entry count");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      nfire_ff <= FIRE_W'(MAX_RESULTS))
      else $error("too many events fired in one tick");

   a_ins_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (idx_ff != '0 && cnt_ff < CW'(TABLE_DEPTH)))
      else $error("insert scan out of range");

   a_event_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_valid) |-> !rsp_ff.status)
      else $error("fired event carries reject status");

endmodule
